@@ hw/rtl/line_grid_cell_walk_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid cell walk core
// Expect signals named clock and reset in the scope of use.
// ----------------------------------------------------------------------------
`ifndef LINE_GRID_CELL_WALK_CORE_ASSERT_SVH
`define LINE_GRID_CELL_WALK_CORE_ASSERT_SVH

// same-cycle implication
`define LGCW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgcw: same-cycle check failed");

// next-cycle implication
`define LGCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgcw: next-cycle check failed");

`endif

@@ hw/rtl/lgcw_pkg.sv @@
// ----------------------------------------------------------------------------
// lgcw_pkg
// Constants, types and codes shared by the grid cell walk core.
// ----------------------------------------------------------------------------
`default_nettype none

package lgcw_pkg;

   localparam int CELL_SHIFT   = 7;
   localparam int GRID_DIM_MAX = 32;
   localparam int MAX_RESULTS  = 63;

   localparam int COORD_W = 16;
   localparam int TAG_W   = 16;
   localparam int DIM_W   = 6;
   localparam int IDX_W   = 10;

   localparam int REL_W   = COORD_W + 1;
   localparam int POS_W   = $clog2(GRID_DIM_MAX);
   localparam int MAP_W   = POS_W + CELL_SHIFT;
   localparam int DELTA_W = MAP_W + 1;
   localparam int PROD_W  = CELL_SHIFT + MAP_W;
   localparam int GAIN_W  = MAP_W + CELL_SHIFT;
   localparam int TERM_W  = GAIN_W + 2;
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PREP,
      ST_WALK,
      ST_REJECT
   } walk_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic prep;
      logic step;
      logic reject;
   } walk_cmd_type;

   typedef struct packed {
      logic outside;
      logic walk_last;
      logic out_free;
   } walk_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/lgcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgcw_ctrl
// Sequencer for one segment: capture, setup, term prep, then cell walk or reject.
// ----------------------------------------------------------------------------
`default_nettype none

module lgcw_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  lgcw_pkg::walk_status_type  status,
   output lgcw_pkg::walk_cmd_type     cmd
);
   import lgcw_pkg::*;

   walk_state_type state_ff;
   walk_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.outside ? ST_REJECT : ST_WALK;
         end
         ST_WALK: begin
            if (status.out_free && status.walk_last) state_in = ST_IDLE;
         end
         ST_REJECT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_WALK: begin
            cmd.step = status.out_free;
         end
         ST_REJECT: begin
            cmd.reject = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/lgcw_datapath.sv @@
// ----------------------------------------------------------------------------
// lgcw_datapath
// Config registers, segment setup, decision term, cell tracking, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lgcw_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_we,
   input  wire  [lgcw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [lgcw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_start_x,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_start_y,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_end_x,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_end_y,
   input  wire  [lgcw_pkg::TAG_W-1:0]            req_segment_id,
   input  lgcw_pkg::walk_cmd_type                cmd,
   output lgcw_pkg::walk_status_type             status,
   input  wire                                   rsp_stall,
   output logic                                  rsp_valid,
   output logic [lgcw_pkg::IDX_W-1:0]            rsp_cell_index,
   output logic [lgcw_pkg::TAG_W-1:0]            rsp_segment_tag,
   output logic                                  rsp_last_cell,
   output logic                                  rsp_outside_grid
);
   import lgcw_pkg::*;

   // configuration
   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;
   logic [DIM_W-1:0]   grid_cols_ff;
   logic [DIM_W-1:0]   grid_rows_ff;
   logic [DIM_W-1:0]   cols_use;
   logic [DIM_W-1:0]   rows_use;

   // captured segment, offsets from grid origin
   logic [REL_W-1:0]   rel_x_ff, rel_y_ff, rel_ex_ff, rel_ey_ff;
   logic [TAG_W-1:0]   tag_ff;

   // setup logic
   logic [REL_W-1:0]   ext_cols, ext_rows;
   logic               inside_all;
   logic [MAP_W-1:0]   px, py, pex, pey;
   logic [DELTA_W-1:0] dx, dy, neg_dx, neg_dy;
   logic               x_neg_in, y_neg_in;
   logic [MAP_W-1:0]   adx, ady;
   logic [CELL_SHIFT-1:0] fa, fb;
   logic [PROD_W-1:0]  prod_a_in, prod_b_in;
   logic [IDX_W-1:0]   idx_start;

   // setup registers
   logic [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   logic [GAIN_W-1:0]  x_gain_ff, y_gain_ff;
   logic               x_neg_ff, y_neg_ff;
   logic               adx_zero_ff, ady_zero_ff;
   logic               outside_ff;
   logic [POS_W-1:0]   ecol_ff, erow_ff;

   // walk registers
   logic [POS_W-1:0]   col_ff, row_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [TERM_W-1:0]  term_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic               term_neg, at_end, cnt_full, x_blocked, y_blocked, walk_last;

   // output word
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   cell_ff;
   logic [TAG_W-1:0]   rtag_ff;
   logic               last_ff, outside_out_ff;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         grid_cols_ff <= DIM_W'(GRID_DIM_MAX);
         grid_rows_ff <= DIM_W'(GRID_DIM_MAX);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[COORD_W-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[DIM_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cols_use = grid_cols_ff;
      if (grid_cols_ff == '0) cols_use = DIM_W'(1);
      else if (grid_cols_ff > DIM_W'(GRID_DIM_MAX)) cols_use = DIM_W'(GRID_DIM_MAX);
      rows_use = grid_rows_ff;
      if (grid_rows_ff == '0) rows_use = DIM_W'(1);
      else if (grid_rows_ff > DIM_W'(GRID_DIM_MAX)) rows_use = DIM_W'(GRID_DIM_MAX);
   end

   // capture: origin offsets, 17 bit so no wrap
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rel_x_ff  <= {req_start_x[COORD_W-1], req_start_x} - {origin_x_ff[COORD_W-1], origin_x_ff};
         rel_y_ff  <= {req_start_y[COORD_W-1], req_start_y} - {origin_y_ff[COORD_W-1], origin_y_ff};
         rel_ex_ff <= {req_end_x[COORD_W-1], req_end_x} - {origin_x_ff[COORD_W-1], origin_x_ff};
         rel_ey_ff <= {req_end_y[COORD_W-1], req_end_y} - {origin_y_ff[COORD_W-1], origin_y_ff};
         tag_ff    <= req_segment_id;
      end
   end

   always_comb begin
      ext_cols = {{(REL_W-DIM_W){1'b0}}, cols_use} << CELL_SHIFT;
      ext_rows = {{(REL_W-DIM_W){1'b0}}, rows_use} << CELL_SHIFT;
      inside_all = !rel_x_ff[REL_W-1]  && (rel_x_ff  < ext_cols)
                && !rel_ex_ff[REL_W-1] && (rel_ex_ff < ext_cols)
                && !rel_y_ff[REL_W-1]  && (rel_y_ff  < ext_rows)
                && !rel_ey_ff[REL_W-1] && (rel_ey_ff < ext_rows);

      px  = rel_x_ff[MAP_W-1:0];
      py  = rel_y_ff[MAP_W-1:0];
      pex = rel_ex_ff[MAP_W-1:0];
      pey = rel_ey_ff[MAP_W-1:0];

      dx       = {1'b0, pex} - {1'b0, px};
      dy       = {1'b0, pey} - {1'b0, py};
      neg_dx   = -dx;
      neg_dy   = -dy;
      x_neg_in = dx[DELTA_W-1];
      y_neg_in = dy[DELTA_W-1];
      adx      = x_neg_in ? neg_dx[MAP_W-1:0] : dx[MAP_W-1:0];
      ady      = y_neg_in ? neg_dy[MAP_W-1:0] : dy[MAP_W-1:0];

      // distance to the cell face in the step direction
      fa = x_neg_in ? px[CELL_SHIFT-1:0] : ~px[CELL_SHIFT-1:0];
      fb = y_neg_in ? py[CELL_SHIFT-1:0] : ~py[CELL_SHIFT-1:0];

      prod_a_in = PROD_W'(fa) * PROD_W'(ady);
      prod_b_in = PROD_W'(fb) * PROD_W'(adx);

      idx_start = IDX_W'(py[MAP_W-1:CELL_SHIFT]) * IDX_W'(cols_use)
                + IDX_W'(px[MAP_W-1:CELL_SHIFT]);
   end

   // walk status
   always_comb begin
      term_neg  = term_ff[TERM_W-1];
      at_end    = (col_ff == ecol_ff) && (row_ff == erow_ff);
      cnt_full  = (cnt_ff == CNT_W'(MAX_RESULTS - 1));
      x_blocked = x_neg_ff ? (col_ff == '0) : (DIM_W'(col_ff) == cols_use - DIM_W'(1));
      y_blocked = y_neg_ff ? (row_ff == '0) : (DIM_W'(row_ff) == rows_use - DIM_W'(1));
      walk_last = at_end || cnt_full || (term_neg ? x_blocked : y_blocked);
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         x_gain_ff   <= {ady, {CELL_SHIFT{1'b0}}};
         y_gain_ff   <= {adx, {CELL_SHIFT{1'b0}}};
         x_neg_ff    <= x_neg_in;
         y_neg_ff    <= y_neg_in;
         adx_zero_ff <= (adx == '0);
         ady_zero_ff <= (ady == '0);
         outside_ff  <= !inside_all;
         col_ff      <= px[MAP_W-1:CELL_SHIFT];
         row_ff      <= py[MAP_W-1:CELL_SHIFT];
         ecol_ff     <= pex[MAP_W-1:CELL_SHIFT];
         erow_ff     <= pey[MAP_W-1:CELL_SHIFT];
         idx_ff      <= idx_start;
      end else if (cmd.prep) begin
         cnt_ff <= '0;
         if (adx_zero_ff) begin
            term_ff <= TERM_W'(1);
         end else if (ady_zero_ff) begin
            term_ff <= '1;
         end else begin
            term_ff <= TERM_W'(prod_a_ff) - TERM_W'(prod_b_ff);
         end
      end else if (cmd.step && !walk_last) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (term_neg) begin
            col_ff  <= x_neg_ff ? col_ff - POS_W'(1) : col_ff + POS_W'(1);
            idx_ff  <= x_neg_ff ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);
            term_ff <= term_ff + TERM_W'(x_gain_ff);
         end else begin
            row_ff  <= y_neg_ff ? row_ff - POS_W'(1) : row_ff + POS_W'(1);
            idx_ff  <= y_neg_ff ? idx_ff - IDX_W'(cols_use) : idx_ff + IDX_W'(cols_use);
            term_ff <= term_ff - TERM_W'(y_gain_ff);
         end
      end
   end

   // output word register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step || cmd.reject) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step || cmd.reject) begin
         cell_ff        <= cmd.reject ? '0 : idx_ff;
         rtag_ff        <= tag_ff;
         last_ff        <= cmd.reject ? 1'b1 : walk_last;
         outside_out_ff <= cmd.reject;
      end
   end

   assign status.outside   = outside_ff;
   assign status.walk_last = walk_last;
   assign status.out_free  = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = cell_ff;
   assign rsp_segment_tag  = rtag_ff;
   assign rsp_last_cell    = last_ff;
   assign rsp_outside_grid = outside_out_ff;

endmodule

`default_nettype wire

@@ hw/rtl/line_grid_cell_walk_core.sv @@
// ----------------------------------------------------------------------------
// line_grid_cell_walk_core
// Walks a line segment across a square cell grid and emits one word per
// cell crossed, in walk order, tagged with the segment number.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  start_x/y, end_x/y, segment_id
//   rsp_      out   rsp_valid/rsp_stall  cell_index, segment_tag, last_cell,
//                                        outside_grid
//   csr_      in    csr_we               csr_index, csr_wdata
//
// A segment yields at most 63 result words, or one outside_grid word if an
//   endpoint is off the grid; the rsp side can stall the walk.
// One segment at a time; the walk loop emits one cell per cycle unless rsp stalls.
// Reset: synchronous, active high; grid is 32 x 32 at origin (0, 0).
// req_stall is high from the accept until the last word enters the output
//   register, so the next segment can be taken while that word still waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_grid_cell_walk_core_assert.svh"

module line_grid_cell_walk_core (
   input  wire                                   clock,
   input  wire                                   reset,
   // configuration
   input  wire                                   csr_we,
   input  wire  [lgcw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [lgcw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // segment words in
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_start_x,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_start_y,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_end_x,
   input  wire  signed [lgcw_pkg::COORD_W-1:0]   req_end_y,
   input  wire  [lgcw_pkg::TAG_W-1:0]            req_segment_id,
   // cell words out
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [lgcw_pkg::IDX_W-1:0]            rsp_cell_index,
   output logic [lgcw_pkg::TAG_W-1:0]            rsp_segment_tag,
   output logic                                  rsp_last_cell,
   output logic                                  rsp_outside_grid
);
   import lgcw_pkg::*;

   walk_cmd_type    cmd;
   walk_status_type status;

   // Controller: IDLE -> SETUP -> PREP -> WALK (or REJECT) -> IDLE.
   // SETUP does the bounds check, deltas and the two face-distance products;
   // PREP forms the decision term from the registered products.
   lgcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: config, setup, term update and the output word register.
   // Cell index is tracked by +-1 for x steps and +-cols for y steps.
   lgcw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_segment_id   (req_segment_id),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_segment_tag  (rsp_segment_tag),
      .rsp_last_cell    (rsp_last_cell),
      .rsp_outside_grid (rsp_outside_grid)
   );

   // a taken segment keeps the input side closed while it is worked on
   `LGCW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // an off-grid word is always the only, hence last, word of its segment
   `LGCW_ASSERT_SAME(a_outside_is_last, rsp_valid && rsp_outside_grid, rsp_last_cell)
   // the input side reopens only once the closing word is in the output register
   `LGCW_ASSERT_SAME(a_reopen_on_last, $fell(req_stall) && !$past(reset), rsp_valid && rsp_last_cell)

endmodule

`default_nettype wire
